// File: design/fust_pkg.sv
// Package for the first unique symbol tracker.
// Holds the cell link and command types shared by the cell, the row and the top level.
// No dependencies.
`timescale 1ns / 1ps

package fust_pkg;

  // Width of one stream symbol.
  localparam int unsigned SYM_W = 8;

  // Contents of one list cell as seen by its neighbours.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } fust_cell_t;

  // List operation broadcast to every cell for the accepted beat.
  typedef struct packed {
    logic append;
    logic remove;
  } fust_cmd_t;

endpackage

// File: design/fust_cell.sv
// One cell of the ordered list of once-seen symbols.
// Depends on fust_pkg for the link and command types.
`timescale 1ns / 1ps

module fust_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fust_pkg::SYM_W-1:0]     in_sym,
  input  fust_pkg::fust_cmd_t            cmd,
  input  logic                           shift,
  output logic                           hit,
  input  logic                           prev_valid,
  input  fust_pkg::fust_cell_t           next_cell,
  output fust_pkg::fust_cell_t           cur_cell,
  output fust_pkg::fust_cell_t           nxt_cell
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [fust_pkg::SYM_W-1:0] sym_r;
  logic [fust_pkg::SYM_W-1:0] sym_nxt;

  // This cell holds the incoming symbol.
  assign hit = valid_r && (sym_r == in_sym);

  // Next contents: shift from the younger neighbour on a removal when the match
  // sits here or in an older cell, or take the new symbol when this is the first
  // empty cell on an append.
  always_comb begin
    valid_nxt = valid_r;
    sym_nxt   = sym_r;
    if (cmd.remove && shift) begin
      valid_nxt = next_cell.valid;
      sym_nxt   = next_cell.sym;
    end else if (cmd.append && !valid_r && prev_valid) begin
      valid_nxt = 1'b1;
      sym_nxt   = in_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign cur_cell = '{valid: valid_r, sym: sym_r};
  assign nxt_cell = '{valid: valid_nxt, sym: sym_nxt};

endmodule

// File: design/fust_chain.sv
// Row of list cells, oldest symbol in cell 0.
// Depends on fust_pkg and fust_cell.
`timescale 1ns / 1ps

module fust_chain #(
  parameter int unsigned NUM_CELLS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fust_pkg::SYM_W-1:0] in_sym,
  input  fust_pkg::fust_cmd_t        cmd,
  output logic                       any_hit,
  output fust_pkg::fust_cell_t       head_nxt
);

  localparam int unsigned IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  fust_pkg::fust_cell_t cur   [NUM_CELLS];
  fust_pkg::fust_cell_t nxt   [NUM_CELLS];
  logic [NUM_CELLS-1:0] hit_vec;
  logic [IDX_W-1:0]     hit_idx;

  // Position of the matching cell. Listed symbols are distinct, so at most one
  // cell matches and an OR of the cell positions gives its index.
  always_comb begin
    hit_idx = '0;
    for (int unsigned k = 0; k < NUM_CELLS; k++) begin
      if (hit_vec[k]) begin
        hit_idx = hit_idx | IDX_W'(k);
      end
    end
  end

  // Each cell sees the older cell's valid bit and the younger cell's contents.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    fust_pkg::fust_cell_t next_cell;
    logic                 prev_valid;
    logic                 shift;

    if (k == NUM_CELLS - 1) begin : g_last
      assign next_cell = '{valid: 1'b0, sym: '0};
    end else begin : g_mid
      assign next_cell = cur[k+1];
    end

    if (k == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cur[k-1].valid;
    end

    // Cells at or after the match close the gap on a removal.
    assign shift = (hit_idx <= IDX_W'(k));

    fust_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_sym     (in_sym),
      .cmd        (cmd),
      .shift      (shift),
      .hit        (hit_vec[k]),
      .prev_valid (prev_valid),
      .next_cell  (next_cell),
      .cur_cell   (cur[k]),
      .nxt_cell   (nxt[k])
    );
  end

  assign any_hit  = |hit_vec;
  assign head_nxt = nxt[0];

endmodule

// File: design/first_unique_symbol_tracker.sv
// Top level of the first unique symbol tracker: repeated flags, command decode, result register.
// Depends on fust_pkg and fust_chain.
`timescale 1ns / 1ps

// The block takes one byte symbol per beat and returns, for every beat, the oldest symbol
// seen exactly once so far with a found flag (symbol zero and found low when there is none).
// It accepts one beat per clock cycle, and the result of a beat is offered on the output
// channel in the cycle after it is accepted; input is taken whenever the result register is
// empty or is being emptied in the same cycle. The figure is set by the row of list cells,
// which compares the new symbol in every cell at once and appends or closes the gap in a
// single update; the position of the matching cell is encoded once and every cell compares
// it with its own place in the row. The list starts empty straight out of reset, with no
// clearing pass. Symbols at or above ALPHABET_SIZE leave the state alone and return the
// current answer.
module first_unique_symbol_tracker #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] first_symbol, [8] found, [15:9] zero
);

  localparam int unsigned NUM_CELLS = (ALPHABET_SIZE < 256) ? ALPHABET_SIZE : 256;
  localparam int unsigned IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  logic                       in_accept;
  logic                       in_range;
  logic [IDX_W-1:0]           sym_idx;
  logic                       any_hit;
  logic                       repeated;
  fust_pkg::fust_cmd_t        cmd;
  fust_pkg::fust_cell_t       head_nxt;
  logic [NUM_CELLS-1:0]       repeated_r;
  logic [NUM_CELLS-1:0]       repeated_nxt;
  logic                       out_valid_r;
  logic [fust_pkg::SYM_W-1:0] out_sym_r;
  logic                       out_found_r;

  // Input handshake: the result register either is empty or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Decode the list operation from the repeated flag and the cell match.
  assign in_range = (32'(in_tdata) < ALPHABET_SIZE);
  assign sym_idx  = in_tdata[IDX_W-1:0];
  assign repeated = repeated_r[sym_idx];

  always_comb begin
    cmd.append = in_accept && in_range && !repeated && !any_hit;
    cmd.remove = in_accept && in_range && !repeated && any_hit;
  end

  fust_chain #(
    .NUM_CELLS (NUM_CELLS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_sym   (in_tdata),
    .cmd      (cmd),
    .any_hit  (any_hit),
    .head_nxt (head_nxt)
  );

  // A second occurrence marks the symbol repeated for good.
  always_comb begin
    repeated_nxt = repeated_r;
    if (cmd.remove) begin
      repeated_nxt[sym_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeated_r <= '0;
    end else begin
      repeated_r <= repeated_nxt;
    end
  end

  // Result register, loaded with the head of the list after the update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_sym_r   <= head_nxt.valid ? head_nxt.sym : '0;
      out_found_r <= head_nxt.valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_found_r, out_sym_r};

endmodule

// File: test/first_unique_symbol_tracker_tb.sv
// Self-checking testbench for the first unique symbol tracker.
// Depends on fust_pkg and the first_unique_symbol_tracker top level; reads no files.
`timescale 1ns / 1ps

// Symbols are streamed with bursty valid while the result side stalls on its own pattern,
// with one long hold-off that backs the block up. Every accepted beat is run through a
// local model of the once-seen list, and every result beat is compared with its answer.
module first_unique_symbol_tracker_tb;

  localparam int unsigned SYM_W = fust_pkg::SYM_W;
  localparam int unsigned ALPHABET = 1 << SYM_W;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_AFTER = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [SYM_W-1:0] first_symbol;
    logic             found;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] symbol
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] first_symbol, [8] found, [15:9] zero

  // Symbols waiting to be offered, and answers waiting for their result beat.
  logic [SYM_W-1:0] symbol_feed[$];
  answer_t          pending_answers[$];

  // Local copy of the tracker state: list in arrival order and per-symbol flags.
  logic [SYM_W-1:0] once_order[$];
  bit               seen_twice[ALPHABET];
  bit               in_order[ALPHABET];

  // Occurrence counts used only to shape the stimulus.
  int unsigned      gen_hits[ALPHABET];
  logic [SYM_W-1:0] gen_once[$];

  int unsigned failures = 0;
  int unsigned symbols_taken = 0;
  int unsigned cyc = 0;

  first_unique_symbol_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one symbol to the local list and returns the answer the block should give.
  function automatic answer_t track_symbol(logic [SYM_W-1:0] sym);
    answer_t ans;
    if (!seen_twice[sym]) begin
      if (!in_order[sym]) begin
        once_order.push_back(sym);
        in_order[sym] = 1'b1;
      end else begin
        foreach (once_order[i]) begin
          if (once_order[i] == sym) begin
            once_order.delete(i);
            break;
          end
        end
        in_order[sym] = 1'b0;
        seen_twice[sym] = 1'b1;
      end
    end
    ans.found = (once_order.size() != 0);
    ans.first_symbol = ans.found ? once_order[0] : '0;
    return ans;
  endfunction

  // Queues a symbol and keeps the stimulus-side view of which symbols are seen once.
  task automatic queue_symbol(logic [SYM_W-1:0] sym);
    symbol_feed.push_back(sym);
    if (gen_hits[sym] == 0) begin
      gen_once.push_back(sym);
    end else if (gen_hits[sym] == 1) begin
      foreach (gen_once[i]) begin
        if (gen_once[i] == sym) begin
          gen_once.delete(i);
          break;
        end
      end
    end
    if (gen_hits[sym] < 2) gen_hits[sym]++;
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    logic [SYM_W-1:0] fresh[$];
    int unsigned      pick;
    int unsigned      roll;
    int unsigned      fresh_pct;

    // Directed part: extremes, removal at head, middle and tail, empty list,
    // and a third occurrence that must change nothing.
    queue_symbol(8'h00);
    queue_symbol(8'hFF);
    queue_symbol(8'h00);
    queue_symbol(8'hFF);
    queue_symbol(8'h00);
    queue_symbol(8'h55);
    queue_symbol(8'hAA);
    queue_symbol(8'h01);
    queue_symbol(8'h80);
    queue_symbol(8'hAA);
    queue_symbol(8'h80);
    queue_symbol(8'h55);
    queue_symbol(8'h7F);
    queue_symbol(8'hFE);
    queue_symbol(8'h01);
    queue_symbol(8'h55);
    queue_symbol(8'h7F);
    queue_symbol(8'hFE);
    queue_symbol(8'h10);
    queue_symbol(8'h10);

    // Random part: new symbols early on grow the list long, second hits pull
    // entries out from random positions, and a share of plain random bytes.
    for (int s = 0; s < ALPHABET; s++) begin
      if (gen_hits[s] == 0) fresh.push_back(s[SYM_W-1:0]);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      fresh_pct = (n < 200) ? 70 : 40;
      if (fresh.size() != 0 && roll < fresh_pct) begin
        pick = $urandom_range(0, fresh.size() - 1);
        queue_symbol(fresh[pick]);
        fresh.delete(pick);
      end else if (gen_once.size() != 0 && roll < 90) begin
        pick = $urandom_range(0, gen_once.size() - 1);
        queue_symbol(gen_once[pick]);
      end else begin
        queue_symbol(SYM_W'($urandom_range(0, ALPHABET - 1)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every symbol is taken and answered, then let the block settle.
    @(negedge clk);
    while (symbol_feed.size() != 0 || in_tvalid || pending_answers.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Driver: offers symbols in bursts of random length with random gaps between them.
  always @(posedge clk) begin
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_answers.push_back(track_symbol(in_tdata));
        symbols_taken++;
      end
      if (in_tvalid && !in_tready) begin
        // Beat still on offer: hold it.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (symbol_feed.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= symbol_feed.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall mode rotates through always ready, mostly ready and mostly stalled, plus
  // one long hold-off once enough results have come, so the result register fills and input backs up.
  always @(posedge clk) begin
    int unsigned own_cycles;
    int unsigned results_seen;
    int unsigned hold_left;
    bit          hold_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      own_cycles = 0;
      results_seen = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      own_cycles++;
      if (out_tvalid && out_tready) results_seen++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        case ((own_cycles / 97) % 3)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: compares each result beat with the oldest waiting answer.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no answer waiting: out_tdata %0h", out_tdata);
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[7:0] !== want.first_symbol) begin
          $error("first_symbol mismatch: expected %0h, actual %0h",
                 want.first_symbol, out_tdata[7:0]);
          failures++;
        end
        if (out_tdata[8] !== want.found) begin
          $error("found mismatch: expected %0b, actual %0b", want.found, out_tdata[8]);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
